FILE: hdl/lcdns_pkg.sv
// ----------------------------------------------------------------------------
// lcdns_pkg
// Shared types, codes and constants of the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  // Request codes
  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_INIT   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_CURSOR = 2'd3
  } req_type_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_PULSE_HOLD   = 2'd0;
  localparam logic [1:0] CFG_DATA_SETTLE  = 2'd1;
  localparam logic [1:0] CFG_INSTR_SETTLE = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [7:0]  PULSE_HOLD_RST   = 8'd2;
  localparam logic [15:0] DATA_SETTLE_RST  = 16'd250;
  localparam logic [15:0] INSTR_SETTLE_RST = 16'd1250;

  // Default depth of the byte queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Instruction bytes
  localparam logic [7:0] INS_FUNC_A  = 8'h33;
  localparam logic [7:0] INS_FUNC_B  = 8'h32;
  localparam logic [7:0] INS_FUNC_C  = 8'h2c;
  localparam logic [7:0] INS_ENTRY   = 8'h06;
  localparam logic [7:0] INS_DISPLAY = 8'h0c;
  localparam logic [7:0] INS_CLEAR   = 8'h01;
  localparam logic [7:0] INS_HOME    = 8'h02;
  localparam logic [7:0] LINE0_BASE  = 8'h80;
  localparam logic [7:0] LINE1_BASE  = 8'hc0;

  // Last byte index of each multi-byte command
  localparam logic [2:0] INIT_LAST_IDX  = 3'd6;
  localparam logic [2:0] CLEAR_LAST_IDX = 3'd1;

  localparam logic [15:0] HOLD_MAX = 16'hffff;

  // One byte to be sent on the bus
  typedef struct packed {
    logic [7:0] value;
    logic       sel;    // register select; also picks the data settle
    logic       last;   // final byte of its command
  } byte_item_t;

  // Live configuration
  typedef struct packed {
    logic [7:0]  pulse_hold;
    logic [15:0] data_settle;
    logic [15:0] instr_settle;
  } cfg_t;

  // Initialise sequence, byte by index
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = INS_FUNC_A;
      3'd1:    b = INS_FUNC_B;
      3'd2:    b = INS_FUNC_C;
      3'd3:    b = INS_ENTRY;
      3'd4:    b = INS_DISPLAY;
      3'd5:    b = INS_CLEAR;
      default: b = INS_HOME;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/lcdns_front.sv
// ----------------------------------------------------------------------------
// lcdns_front
// Accepts commands and expands each into bytes, one per cycle unless queue is full.
// ----------------------------------------------------------------------------
module lcdns_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              req_type_i,
  input  logic [7:0]              data_byte_i,
  input  logic                    reg_select_i,
  input  logic [5:0]              column_i,
  input  logic                    line_i,
  input  logic                    full_i,
  output logic                    push_o,
  output lcdns_pkg::byte_item_t   item_o
);
  import lcdns_pkg::*;

  logic       act_q, act_d;
  req_type_e  req_q, req_d;
  logic [7:0] byte_q, byte_d;
  logic       rs_q, rs_d;
  logic [5:0] col_q, col_d;
  logic       ln_q, ln_d;
  logic [2:0] idx_q, idx_d;

  logic [2:0] last_idx;
  logic [7:0] cur_byte;
  logic       cur_sel;
  logic       is_last;
  logic       accept;

  // Select the current byte of the held command
  always_comb begin
    last_idx = 3'd0;
    cur_sel  = 1'b0;
    unique case (req_q)
      REQ_WRITE: begin
        cur_byte = byte_q;
        cur_sel  = rs_q;
      end
      REQ_INIT: begin
        cur_byte = init_byte(idx_q);
        last_idx = INIT_LAST_IDX;
      end
      REQ_CLEAR: begin
        cur_byte = (idx_q == 3'd0) ? INS_CLEAR : INS_HOME;
        last_idx = CLEAR_LAST_IDX;
      end
      REQ_CURSOR: begin
        cur_byte = (ln_q ? LINE1_BASE : LINE0_BASE) + {2'b00, col_q};
      end
      default: begin
        cur_byte = byte_q;
      end
    endcase
  end

  assign is_last     = (idx_q == last_idx);
  assign push_o      = act_q & ~full_i;
  assign busy_o      = act_q & ~(push_o & is_last);
  assign accept      = start_i & ~busy_o;
  assign item_o.value = cur_byte;
  assign item_o.sel   = cur_sel;
  assign item_o.last  = is_last;

  // Load a new command or advance through the held one
  always_comb begin
    act_d  = act_q;
    req_d  = req_q;
    byte_d = byte_q;
    rs_d   = rs_q;
    col_d  = col_q;
    ln_d   = ln_q;
    idx_d  = idx_q;
    if (accept) begin
      act_d  = 1'b1;
      req_d  = req_type_e'(req_type_i);
      byte_d = data_byte_i;
      rs_d   = reg_select_i;
      col_d  = column_i;
      ln_d   = line_i;
      idx_d  = 3'd0;
    end else if (push_o) begin
      if (is_last) begin
        act_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      idx_q <= 3'd0;
    end else begin
      act_q <= act_d;
      idx_q <= idx_d;
    end
  end

  // Command payload
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    byte_q <= byte_d;
    rs_q   <= rs_d;
    col_q  <= col_d;
    ln_q   <= ln_d;
  end

endmodule

FILE: hdl/lcdns_queue.sv
// ----------------------------------------------------------------------------
// lcdns_queue
// Short FIFO of bytes between the command front and the phase back.
// ----------------------------------------------------------------------------
module lcdns_queue #(
  parameter int unsigned Depth = lcdns_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lcdns_pkg::byte_item_t item_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output lcdns_pkg::byte_item_t item_o,
  output logic                  empty_o
);
  import lcdns_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  byte_item_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_q];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

FILE: hdl/lcdns_back.sv
// ----------------------------------------------------------------------------
// lcdns_back
// Plays each queued byte as four bus phases, one phase per cycle.
// ----------------------------------------------------------------------------
module lcdns_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcdns_pkg::cfg_t       cfg_i,
  input  logic                  empty_i,
  input  lcdns_pkg::byte_item_t item_i,
  output logic                  pop_o,
  output logic                  valid_o,
  output logic [3:0]            bus_nibble_o,
  output logic                  select_line_o,
  output logic                  enable_line_o,
  output logic [15:0]           hold_ticks_o,
  output logic                  last_phase_o
);
  import lcdns_pkg::*;

  logic       act_q, act_d;
  logic [1:0] ph_q, ph_d;
  byte_item_t item_q, item_d;
  logic       take;
  logic       final_ph;

  logic [15:0] settle;
  logic [16:0] tail_sum;
  logic [15:0] tail;

  logic        valid_q;
  logic [3:0]  nib_q, nib_d;
  logic        sel_q;
  logic        en_q, en_d;
  logic [15:0] hold_q, hold_d;
  logic        last_q, last_d;

  assign final_ph = (ph_q == 2'd3);
  assign take     = ~empty_i & (~act_q | final_ph);
  assign pop_o    = take;

  // Saturating tail hold of the last low phase
  assign settle   = item_q.sel ? cfg_i.data_settle : cfg_i.instr_settle;
  assign tail_sum = {1'b0, settle} + {9'd0, cfg_i.pulse_hold};
  assign tail     = tail_sum[16] ? HOLD_MAX : tail_sum[15:0];

  // Sequence phases and fetch the next byte
  always_comb begin
    act_d  = act_q;
    ph_d   = ph_q;
    item_d = item_q;
    if (take) begin
      act_d  = 1'b1;
      ph_d   = 2'd0;
      item_d = item_i;
    end else if (act_q) begin
      act_d = ~final_ph;
      ph_d  = ph_q + 2'd1;
    end
  end

  // Form the phase: high nibble first, enable high then low
  always_comb begin
    nib_d  = ph_q[1] ? item_q.value[3:0] : item_q.value[7:4];
    en_d   = ~ph_q[0];
    hold_d = final_ph ? tail : {8'd0, cfg_i.pulse_hold};
    last_d = final_ph & item_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      ph_q    <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      act_q   <= act_d;
      ph_q    <= ph_d;
      valid_q <= act_q;
    end
  end

  // Byte and output payload
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    nib_q  <= nib_d;
    sel_q  <= item_q.sel;
    en_q   <= en_d;
    hold_q <= hold_d;
    last_q <= last_d;
  end

  assign valid_o       = valid_q;
  assign bus_nibble_o  = nib_q;
  assign select_line_o = sel_q;
  assign enable_line_o = en_q;
  assign hold_ticks_o  = hold_q;
  assign last_phase_o  = last_q;

endmodule

FILE: hdl/character_lcd_nibble_sequencer_top.sv
// A command's first phase passes front, queue, back phase and output registers.
// Throughput: one phase per cycle, four per byte; a command gives 4 to 28 phases.
// The back's phase sequencer sets the rate; the byte queue lets new commands
// be taken while earlier bytes still play. Results cannot be stalled.
// Reset clears queue, sequencers and output strobe and loads the default
// pulse hold and settle registers.
// ----------------------------------------------------------------------------
// character_lcd_nibble_sequencer_top
// HD44780-style 4-bit bus sequencer: commands in, timed pin phases out.
// ----------------------------------------------------------------------------
module character_lcd_nibble_sequencer_top #(
  parameter int unsigned QueueDepth = lcdns_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      req_type_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            reg_select_i,
  input  logic [5:0]                      column_i,
  input  logic                            line_i,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [lcdns_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            valid_o,
  output logic [3:0]                      bus_nibble_o,
  output logic                            select_line_o,
  output logic                            enable_line_o,
  output logic [15:0]                     hold_ticks_o,
  output logic                            last_phase_o
);
  import lcdns_pkg::*;

  cfg_t       cfg_q;
  logic       q_full, q_empty, q_push, q_pop;
  byte_item_t push_item, pop_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_hold   <= PULSE_HOLD_RST;
      cfg_q.data_settle  <= DATA_SETTLE_RST;
      cfg_q.instr_settle <= INSTR_SETTLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PULSE_HOLD:   cfg_q.pulse_hold   <= cfg_data_i[7:0];
        CFG_DATA_SETTLE:  cfg_q.data_settle  <= cfg_data_i[15:0];
        CFG_INSTR_SETTLE: cfg_q.instr_settle <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  lcdns_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .reg_select_i (reg_select_i),
    .column_i     (column_i),
    .line_i       (line_i),
    .full_i       (q_full),
    .push_o       (q_push),
    .item_o       (push_item)
  );

  lcdns_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (pop_item),
    .empty_o (q_empty)
  );

  lcdns_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .empty_i       (q_empty),
    .item_i        (pop_item),
    .pop_o         (q_pop),
    .valid_o       (valid_o),
    .bus_nibble_o  (bus_nibble_o),
    .select_line_o (select_line_o),
    .enable_line_o (enable_line_o),
    .hold_ticks_o  (hold_ticks_o),
    .last_phase_o  (last_phase_o)
  );

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character LCD nibble sequencer. Commands go in
// through the start/busy handshake with random gaps, the pin phases that come
// out are compared field by field against phases computed here from a local
// copy of the pulse hold and settle registers. Registers are rewritten between
// test sections once the display side has gone quiet.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdns_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_WAIT  = 12;
  localparam int unsigned ROUNDS       = 7;
  localparam int unsigned ROUND_ITEMS  = 40;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;
  localparam logic [7:0]  INIT_BYTES [7] = '{INS_FUNC_A, INS_FUNC_B, INS_FUNC_C,
                                              INS_ENTRY, INS_DISPLAY, INS_CLEAR,
                                              INS_HOME};

  typedef struct packed {
    logic [3:0]  nibble;
    logic        sel;
    logic        en;
    logic [15:0] hold;
    logic        last;
  } lcd_phase_t;

  // Expected pin phases, computed from a mirror of the registers
  class phase_scoreboard;
    logic [7:0]  pulse_hold   = PULSE_HOLD_RST;
    logic [15:0] data_settle  = DATA_SETTLE_RST;
    logic [15:0] instr_settle = INSTR_SETTLE_RST;
    lcd_phase_t  pending[$];
    int unsigned fail_count   = 0;

    function void write_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CFG_PULSE_HOLD:   pulse_hold   = value[7:0];
        CFG_DATA_SETTLE:  data_settle  = value;
        CFG_INSTR_SETTLE: instr_settle = value;
        default: ;
      endcase
    endfunction

    // Four phases per byte: high nibble first, settle on the last low phase
    function void push_byte(logic [7:0] b, logic sel, logic is_data, logic fin);
      logic [16:0] sum;
      logic [15:0] tail;
      sum  = {9'd0, pulse_hold} + {1'b0, (is_data ? data_settle : instr_settle)};
      tail = sum[16] ? HOLD_MAX : sum[15:0];
      pending.push_back('{b[7:4], sel, 1'b1, {8'd0, pulse_hold}, 1'b0});
      pending.push_back('{b[7:4], sel, 1'b0, {8'd0, pulse_hold}, 1'b0});
      pending.push_back('{b[3:0], sel, 1'b1, {8'd0, pulse_hold}, 1'b0});
      pending.push_back('{b[3:0], sel, 1'b0, tail, fin});
    endfunction

    function void note_command(req_type_e rt, logic [7:0] b, logic rs,
                               logic [5:0] col, logic ln);
      case (rt)
        REQ_WRITE: push_byte(b, rs, rs, 1'b1);
        REQ_INIT: begin
          for (int i = 0; i < 7; i++) push_byte(INIT_BYTES[i], 1'b0, 1'b0, i == 6);
        end
        REQ_CLEAR: begin
          push_byte(INS_CLEAR, 1'b0, 1'b0, 1'b0);
          push_byte(INS_HOME, 1'b0, 1'b0, 1'b1);
        end
        default: push_byte((ln ? LINE1_BASE : LINE0_BASE) + {2'b00, col},
                           1'b0, 1'b0, 1'b1);
      endcase
    endfunction

    function void report(string field, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
        fail_count++;
      end
    endfunction

    function void check_phase(lcd_phase_t got);
      lcd_phase_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected phase, expected none actual %h", $time, got);
        fail_count++;
      end else begin
        want = pending.pop_front();
        report("bus_nibble", {12'd0, want.nibble}, {12'd0, got.nibble});
        report("select_line", {15'd0, want.sel}, {15'd0, got.sel});
        report("enable_line", {15'd0, want.en}, {15'd0, got.en});
        report("hold_ticks", want.hold, got.hold);
        report("last_phase", {15'd0, want.last}, {15'd0, got.last});
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  req_type_i;
  logic [7:0]  data_byte_i;
  logic        reg_select_i;
  logic [5:0]  column_i;
  logic        line_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic        valid_o;
  logic [3:0]  bus_nibble_o;
  logic        select_line_o;
  logic        enable_line_o;
  logic [15:0] hold_ticks_o;
  logic        last_phase_o;

  phase_scoreboard board = new();
  int unsigned     cycle_count = 0;
  bit              quiet = 1'b0;

  character_lcd_nibble_sequencer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .data_byte_i   (data_byte_i),
    .reg_select_i  (reg_select_i),
    .column_i      (column_i),
    .line_i        (line_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .valid_o       (valid_o),
    .bus_nibble_o  (bus_nibble_o),
    .select_line_o (select_line_o),
    .enable_line_o (enable_line_o),
    .hold_ticks_o  (hold_ticks_o),
    .last_phase_o  (last_phase_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort on a hang
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Check every phase strobe against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      board.check_phase('{bus_nibble_o, select_line_o, enable_line_o,
                          hold_ticks_o, last_phase_o});
    end
  end

  // Hold start high until the transfer is taken; start stays high on return
  task automatic send_command(input req_type_e rt, input logic [7:0] b,
                              input logic rs, input logic [5:0] col, input logic ln);
    if (!quiet) begin
      while ($urandom_range(99) < 12) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start        <= 1'b1;
    req_type_i   <= rt;
    data_byte_i  <= b;
    reg_select_i <= rs;
    column_i     <= col;
    line_i       <= ln;
    do @(posedge clk_i); while (busy);
    board.note_command(rt, b, rs, col, ln);
  endtask

  // Drop start and wait until every expected phase has come out
  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    board.write_reg(idx, value);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random();
    req_type_e rt;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55)      rt = REQ_WRITE;
    else if (pick < 65) rt = REQ_INIT;
    else if (pick < 80) rt = REQ_CLEAR;
    else                rt = REQ_CURSOR;
    send_command(rt, 8'($urandom), 1'($urandom), 6'($urandom), 1'($urandom));
  endtask

  function automatic logic [15:0] pick_settle();
    logic [15:0] v;
    case ($urandom_range(3))
      0:       v = 16'h0000;
      1:       v = 16'hffff;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_type_i   = REQ_WRITE;
    data_byte_i  = '0;
    reg_select_i = 1'b0;
    column_i     = '0;
    line_i       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_PULSE_HOLD;
    cfg_data_i   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: every command, byte and cursor extremes, ignored fields
    send_command(REQ_WRITE,  8'h00, 1'b0, 6'h3f, 1'b1);
    send_command(REQ_WRITE,  8'hff, 1'b1, 6'h00, 1'b0);
    send_command(REQ_WRITE,  8'ha5, 1'b0, 6'h15, 1'b0);
    send_command(REQ_WRITE,  8'h5a, 1'b1, 6'h2a, 1'b1);
    send_command(REQ_INIT,   8'hff, 1'b1, 6'h3f, 1'b1);
    send_command(REQ_CLEAR,  8'hc3, 1'b1, 6'h3f, 1'b1);
    send_command(REQ_CURSOR, 8'hff, 1'b1, 6'h00, 1'b0);
    send_command(REQ_CURSOR, 8'h00, 1'b0, 6'h3f, 1'b1);
    send_command(REQ_CURSOR, 8'h77, 1'b0, 6'h2a, 1'b0);
    send_command(REQ_CURSOR, 8'h11, 1'b1, 6'h15, 1'b1);
    wait_drained();

    // Largest hold and settles: the tail saturates
    write_reg(CFG_PULSE_HOLD, 16'h00ff);
    write_reg(CFG_DATA_SETTLE, 16'hffff);
    write_reg(CFG_INSTR_SETTLE, 16'hffff);
    send_command(REQ_WRITE, 8'h3c, 1'b1, 6'h00, 1'b0);
    send_command(REQ_WRITE, 8'hc3, 1'b0, 6'h00, 1'b0);
    send_command(REQ_CLEAR, 8'h00, 1'b0, 6'h00, 1'b0);
    wait_drained();

    // Zero hold through masking of the upper byte, zero settles
    write_reg(CFG_PULSE_HOLD, 16'hff00);
    write_reg(CFG_DATA_SETTLE, 16'h0000);
    write_reg(CFG_INSTR_SETTLE, 16'h0000);
    send_command(REQ_WRITE,  8'h81, 1'b1, 6'h01, 1'b0);
    send_command(REQ_WRITE,  8'h18, 1'b0, 6'h01, 1'b0);
    send_command(REQ_CURSOR, 8'h00, 1'b0, 6'h3f, 1'b0);
    wait_drained();

    // Unused index leaves everything alone; smallest nonzero hold
    write_reg(CFG_UNUSED, 16'hffff);
    write_reg(CFG_PULSE_HOLD, 16'h0001);
    write_reg(CFG_DATA_SETTLE, 16'hfffe);
    send_command(REQ_WRITE, 8'h42, 1'b1, 6'h00, 1'b0);
    send_command(REQ_INIT,  8'h00, 1'b0, 6'h00, 1'b0);
    wait_drained();

    // Random rounds, each with its own register setting
    for (int r = 0; r < ROUNDS; r++) begin
      quiet = (r == 3);
      write_reg(CFG_PULSE_HOLD, 16'($urandom));
      write_reg(CFG_DATA_SETTLE, pick_settle());
      write_reg(CFG_INSTR_SETTLE, pick_settle());
      if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, 16'($urandom));
      for (int n = 0; n < ROUND_ITEMS; n++) send_random();
      wait_drained();
    end

    if (board.fail_count == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: character_lcd_nibble_sequencer_top.f
hdl/lcdns_pkg.sv
hdl/lcdns_front.sv
hdl/lcdns_queue.sv
hdl/lcdns_back.sv
hdl/character_lcd_nibble_sequencer_top.sv
verif/tb.sv
